@@ sv/sdpg_pkg.sv @@
// shared constants, types and helpers for the step/dir pulse generator
`timescale 1ns / 1ps

package sdpg_pkg;

    localparam int POS_WIDTH = 32;
    localparam int REM_CNT_W = $clog2(POS_WIDTH + 1);

    typedef logic [POS_WIDTH-1:0] pos_t;

    // input commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_SLEW  = 2'd2;
    localparam logic [1:0] CMD_TRACK = 2'd3;

    // motion modes
    localparam logic [1:0] MODE_NORMAL   = 2'd0;
    localparam logic [1:0] MODE_SLEW_FWD = 2'd1;
    localparam logic [1:0] MODE_SLEW_REV = 2'd2;

    // slewing request states
    localparam logic [1:0] MS_TRACKING = 2'd0;
    localparam logic [1:0] MS_REQUEST  = 2'd1;
    localparam logic [1:0] MS_READY    = 2'd2;

    // move directions
    localparam logic [1:0] DIR_IDLE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_MOTION_MODE  = 3'd0;
    localparam logic [2:0] REG_TRACK_EN     = 3'd1;
    localparam logic [2:0] REG_TRACK_INC    = 3'd2;
    localparam logic [2:0] REG_STEP_SIZE    = 3'd3;
    localparam logic [2:0] REG_SLEW_SIZE    = 3'd4;
    localparam logic [2:0] REG_BACKLASH     = 3'd5;
    localparam logic [2:0] REG_GRANULARITY  = 3'd6;
    localparam logic [2:0] REG_DIR_REVERSE  = 3'd7;

    typedef struct packed {
        logic cap_in;
        logic exec;
        logic rem_start;
        logic grant;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_rem;
        logic rem_busy;
    } dp_stat_t;

    // position to the 32-bit port: sign-extend or keep the low bits
    function automatic logic [31:0] pos_to_port(pos_t v);
        logic signed [63:0] ext;
        ext = 64'(signed'(v));
        return ext[31:0];
    endfunction

endpackage

@@ sv/sdpg_rem.sv @@
// iterative remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module sdpg_rem (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  sdpg_pkg::pos_t      dividend,
    input  logic [8:0]          divisor,
    output logic                busy,
    output logic                rem_zero
);

    logic [sdpg_pkg::REM_CNT_W-1:0] cnt_reg, cnt_next;
    sdpg_pkg::pos_t                 shift_reg, shift_next;
    logic [8:0]                     rem_reg, rem_next;
    logic [8:0]                     div_reg, div_next;
    logic [9:0]                     trial;

    assign busy     = (cnt_reg != '0);
    assign rem_zero = (rem_reg == 9'd0);
    assign trial    = {rem_reg, shift_reg[sdpg_pkg::POS_WIDTH-1]};

    always_comb
    begin
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        if (start)
        begin
            cnt_next   = sdpg_pkg::REM_CNT_W'(sdpg_pkg::POS_WIDTH);
            shift_next = dividend;
            rem_next   = 9'd0;
            // zero granularity acts as one
            div_next   = (divisor == 9'd0) ? 9'd1 : divisor;
        end
        else if (busy)
        begin
            cnt_next   = cnt_reg - 1'b1;
            shift_next = {shift_reg[sdpg_pkg::POS_WIDTH-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
                rem_next = 9'(trial - {1'b0, div_reg});
            else
                rem_next = trial[8:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

endmodule

@@ sv/sdpg_datapath.sv @@
// position, target and backlash registers, configuration and result registers
`timescale 1ns / 1ps

module sdpg_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sdpg_pkg::ctrl_cmd_t   ctl,
    output sdpg_pkg::dp_stat_t    stat,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic [1:0]            cmd,
    input  logic signed [31:0]    target_value,
    output logic                  step_active,
    output logic                  dir_level,
    output logic [1:0]            move_direction,
    output logic signed [31:0]    motor_position,
    output logic signed [31:0]    backlash_position,
    output logic                  slewing_ready
);

    localparam int PW = sdpg_pkg::POS_WIDTH;

    // configuration
    logic [1:0]        mode_reg;
    logic              trk_en_reg;
    logic signed [9:0] trk_inc_reg;
    logic [8:0]        step_size_reg;
    logic [8:0]        slew_size_reg;
    logic [15:0]       bl_amt_reg;
    logic [8:0]        gran_reg;
    logic              dir_rev_reg;

    // captured input beat
    logic [1:0]        cmd_reg;
    sdpg_pkg::pos_t    tgt_in_reg;

    // motion state
    logic              phase_reg, phase_next;
    logic [1:0]        dir_reg, dir_next;
    sdpg_pkg::pos_t    motor_reg, motor_next;
    sdpg_pkg::pos_t    bl_reg, bl_next;
    sdpg_pkg::pos_t    target_reg, target_next;
    logic [1:0]        ms_reg, ms_next;
    logic              dir_pin_reg, dir_pin_next;
    logic              step_pin_reg, step_pin_next;

    // result registers
    logic              out_step_reg;
    logic              out_dir_pin_reg;
    logic [1:0]        out_dir_reg;
    logic [31:0]       out_motor_reg;
    logic [31:0]       out_bl_reg;
    logic              out_ready_reg;

    sdpg_pkg::pos_t    trk_target;
    sdpg_pkg::pos_t    sum;
    sdpg_pkg::pos_t    mag;
    sdpg_pkg::pos_t    step_ext;
    sdpg_pkg::pos_t    slew_ext;
    sdpg_pkg::pos_t    slew_target;
    sdpg_pkg::pos_t    slew_motor;
    logic              slew_fwd;
    logic              slew_move;
    logic              need_fwd;
    logic              need_rev;
    logic              bl_take_fwd;
    logic              bl_take_rev;
    logic              is_slew;
    logic              rem_busy;
    logic              rem_zero;

    assign step_ext = PW'(step_size_reg);
    assign slew_ext = PW'(slew_size_reg);
    assign is_slew  = (mode_reg == sdpg_pkg::MODE_SLEW_FWD) ||
                      (mode_reg == sdpg_pkg::MODE_SLEW_REV);

    // decide half: tracked target against motor plus backlash
    assign trk_target = trk_en_reg ? (target_reg + PW'(trk_inc_reg)) : target_reg;
    assign sum        = motor_reg + bl_reg;
    assign need_fwd   = $signed(sum) < $signed(trk_target);
    assign need_rev   = $signed(trk_target) < $signed(sum);
    assign mag        = sum[PW-1] ? (~sum + 1'b1) : sum;

    // step half: backlash is taken up before the motor moves
    assign bl_take_fwd = bl_reg[PW-1] || (bl_reg < PW'(bl_amt_reg));
    assign bl_take_rev = !bl_reg[PW-1] && (bl_reg != '0);

    // fast slew only steps toward the target
    assign slew_fwd    = (mode_reg == sdpg_pkg::MODE_SLEW_FWD);
    assign slew_target = !trk_en_reg ? target_reg :
                         slew_fwd ? (target_reg + slew_ext) : (target_reg - slew_ext);
    assign slew_move   = slew_fwd ? ($signed(motor_reg) < $signed(slew_target))
                                  : ($signed(slew_target) < $signed(motor_reg));
    assign slew_motor  = slew_fwd ? (motor_reg + slew_ext) : (motor_reg - slew_ext);

    assign stat.need_rem = (cmd_reg == sdpg_pkg::CMD_TICK) && !is_slew && !phase_reg &&
                           (ms_reg == sdpg_pkg::MS_REQUEST);
    assign stat.rem_busy = rem_busy;

    sdpg_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.rem_start),
        .dividend (mag),
        .divisor  (gran_reg),
        .busy     (rem_busy),
        .rem_zero (rem_zero)
    );

    always_comb
    begin
        phase_next    = phase_reg;
        dir_next      = dir_reg;
        motor_next    = motor_reg;
        bl_next       = bl_reg;
        target_next   = target_reg;
        ms_next       = ms_reg;
        dir_pin_next  = dir_pin_reg;
        step_pin_next = step_pin_reg;
        if (ctl.exec)
        begin
            unique case (cmd_reg)
                sdpg_pkg::CMD_LOAD:  target_next = tgt_in_reg;
                sdpg_pkg::CMD_SLEW:  ms_next = sdpg_pkg::MS_REQUEST;
                sdpg_pkg::CMD_TRACK: ms_next = sdpg_pkg::MS_TRACKING;
                sdpg_pkg::CMD_TICK:
                begin
                    priority if (is_slew)
                    begin
                        phase_next = !phase_reg;
                        if (phase_reg)
                        begin
                            target_next = slew_target;
                            if (slew_move)
                            begin
                                motor_next    = slew_motor;
                                step_pin_next = 1'b1;
                            end
                        end
                        else
                            step_pin_next = 1'b0;
                    end
                    else if (ms_reg != sdpg_pkg::MS_READY)
                    begin
                        phase_next = !phase_reg;
                        if (!phase_reg)
                        begin
                            target_next   = trk_target;
                            step_pin_next = 1'b0;
                            priority if (need_fwd)
                            begin
                                dir_next     = sdpg_pkg::DIR_FWD;
                                dir_pin_next = dir_rev_reg;
                            end
                            else if (need_rev)
                            begin
                                dir_next     = sdpg_pkg::DIR_REV;
                                dir_pin_next = !dir_rev_reg;
                            end
                            else
                                dir_next = sdpg_pkg::DIR_IDLE;
                        end
                        else if (dir_reg == sdpg_pkg::DIR_FWD)
                        begin
                            if (bl_take_fwd)
                                bl_next = bl_reg + step_ext;
                            else
                                motor_next = motor_reg + step_ext;
                            step_pin_next = 1'b1;
                        end
                        else if (dir_reg == sdpg_pkg::DIR_REV)
                        begin
                            if (bl_take_rev)
                                bl_next = bl_reg - step_ext;
                            else
                                motor_next = motor_reg - step_ext;
                            step_pin_next = 1'b1;
                        end
                    end
                    // ready halt: nothing changes
                end
            endcase
        end
        // slewing request granted once the position is a granularity multiple
        if (ctl.grant && rem_zero)
            ms_next = sdpg_pkg::MS_READY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= sdpg_pkg::MODE_NORMAL;
            trk_en_reg    <= 1'b0;
            trk_inc_reg   <= '0;
            step_size_reg <= 9'd1;
            slew_size_reg <= 9'd1;
            bl_amt_reg    <= '0;
            gran_reg      <= 9'd1;
            dir_rev_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sdpg_pkg::REG_MOTION_MODE: mode_reg      <= cfg_data[1:0];
                sdpg_pkg::REG_TRACK_EN:    trk_en_reg    <= cfg_data[0];
                sdpg_pkg::REG_TRACK_INC:   trk_inc_reg   <= cfg_data[9:0];
                sdpg_pkg::REG_STEP_SIZE:   step_size_reg <= cfg_data[8:0];
                sdpg_pkg::REG_SLEW_SIZE:   slew_size_reg <= cfg_data[8:0];
                sdpg_pkg::REG_BACKLASH:    bl_amt_reg    <= cfg_data;
                sdpg_pkg::REG_GRANULARITY: gran_reg      <= cfg_data[8:0];
                sdpg_pkg::REG_DIR_REVERSE: dir_rev_reg   <= cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= 1'b0;
            dir_reg      <= sdpg_pkg::DIR_IDLE;
            motor_reg    <= '0;
            bl_reg       <= '0;
            target_reg   <= '0;
            ms_reg       <= sdpg_pkg::MS_TRACKING;
            dir_pin_reg  <= 1'b0;
            step_pin_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            dir_reg      <= dir_next;
            motor_reg    <= motor_next;
            bl_reg       <= bl_next;
            target_reg   <= target_next;
            ms_reg       <= ms_next;
            dir_pin_reg  <= dir_pin_next;
            step_pin_reg <= step_pin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cap_in)
        begin
            cmd_reg    <= cmd;
            tgt_in_reg <= PW'(target_value);
        end
        if (ctl.out_load)
        begin
            out_step_reg    <= step_pin_reg;
            out_dir_pin_reg <= dir_pin_reg;
            out_dir_reg     <= dir_reg;
            out_motor_reg   <= sdpg_pkg::pos_to_port(motor_reg);
            out_bl_reg      <= sdpg_pkg::pos_to_port(bl_reg);
            out_ready_reg   <= (ms_reg == sdpg_pkg::MS_READY);
        end
    end

    assign step_active       = out_step_reg;
    assign dir_level         = out_dir_pin_reg;
    assign move_direction    = out_dir_reg;
    assign motor_position    = signed'(out_motor_reg);
    assign backlash_position = signed'(out_bl_reg);
    assign slewing_ready     = out_ready_reg;

endmodule

@@ sv/sdpg_ctrl.sv @@
// sequencing of one input beat: capture, execute, remainder wait, result
`timescale 1ns / 1ps

module sdpg_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  sdpg_pkg::dp_stat_t    stat,
    output sdpg_pkg::ctrl_cmd_t   ctl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_REM  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    // result register can take a new beat when empty or being drained
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctl            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.cap_in = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.exec = 1'b1;
                if (stat.need_rem)
                begin
                    ctl.rem_start = 1'b1;
                    state_next    = ST_REM;
                end
                else
                    state_next = ST_DONE;
            end
            ST_REM:
            begin
                if (!stat.rem_busy)
                begin
                    ctl.grant  = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ctl.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ sv/step_dir_pulse_generator.sv @@
// step/dir pulse generator top level: handshakes, controller and datapath
// each input beat is captured, executed and then loaded into the result register; a remainder
//   wait comes before the load when a decide half checks a pending slewing request (bit-serial remainder)
// the input is not ready again until the previous beat is loaded, which waits for a free result register
// the result register holds one beat so a new input is taken while it waits
// reset: async active low; all positions, target and modes clear, step size 1
`timescale 1ns / 1ps

module step_dir_pulse_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] target_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               step_active,
    output logic               dir_level,
    output logic [1:0]         move_direction,
    output logic signed [31:0] motor_position,
    output logic signed [31:0] backlash_position,
    output logic               slewing_ready
);

    sdpg_pkg::ctrl_cmd_t ctl;
    sdpg_pkg::dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    sdpg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    sdpg_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .stat              (stat),
        .cfg_we            (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .cmd               (cmd),
        .target_value      (target_value),
        .step_active       (step_active),
        .dir_level         (dir_level),
        .move_direction    (move_direction),
        .motor_position    (motor_position),
        .backlash_position (backlash_position),
        .slewing_ready     (slewing_ready)
    );

endmodule
